### rtl/ftda_pkg.sv
// Shared constants and types for the float-to-decimal text formatter.
// No dependencies; used by ftda_bcd and float_to_decimal_ascii_core.
package ftda_pkg;

  localparam int unsigned MAX_FRAC_DIGITS = 9;

  localparam int unsigned BIN_W      = 32;
  localparam int unsigned BCD_DIGITS = 10;
  localparam int unsigned BCD_W      = 4 * BCD_DIGITS;
  localparam int unsigned FRAC_W     = 59;   // fraction kept as F / 2^59
  localparam int unsigned FIX_W      = BIN_W + FRAC_W;
  localparam int unsigned FD_W       = 4;

  localparam logic [FD_W-1:0]  FD_RESET  = 4'd6;
  localparam logic [FD_W-1:0]  FD_MAX    = 4'(MAX_FRAC_DIGITS);
  localparam logic [BIN_W-1:0] SAT_INT   = 32'h7FFF_FFFF;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  // Status of the serial binary-to-BCD converter
  typedef struct packed {
    logic busy;
    logic done;
  } bcd_stat_t;

endpackage

### rtl/ftda_bcd.sv
// Serial binary-to-BCD converter (shift-and-add-3), two bits per cycle.
// Depends on ftda_pkg.
module ftda_bcd (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ftda_pkg::BIN_W-1:0]    bin_i,
  output logic [ftda_pkg::BCD_W-1:0]    bcd_o,
  output ftda_pkg::bcd_stat_t           stat_o
);

  localparam int unsigned STEPS = ftda_pkg::BIN_W / 2;
  localparam int unsigned CNT_W = $clog2(STEPS);

  logic [ftda_pkg::BIN_W-1:0] bin_q, bin_d;
  logic [ftda_pkg::BCD_W-1:0] bcd_q, bcd_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;

  // One shift-and-add-3 step: correct each digit, then shift in one bit
  function automatic logic [ftda_pkg::BCD_W-1:0] dabble(
    input logic [ftda_pkg::BCD_W-1:0] v,
    input logic                       b
  );
    logic [ftda_pkg::BCD_W-1:0] c;
    c = v;
    for (int i = 0; i < int'(ftda_pkg::BCD_DIGITS); i++) begin
      if (c[4*i +: 4] >= 4'd5) begin
        c[4*i +: 4] = c[4*i +: 4] + 4'd3;
      end
    end
    return {c[ftda_pkg::BCD_W-2:0], b};
  endfunction

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      bin_d  = bin_i;
      bcd_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      bcd_d = dabble(dabble(bcd_q, bin_q[ftda_pkg::BIN_W-1]), bin_q[ftda_pkg::BIN_W-2]);
      bin_d = {bin_q[ftda_pkg::BIN_W-3:0], 2'b00};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign bcd_o       = bcd_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

### rtl/float_to_decimal_ascii_core.sv
// Float-to-decimal text formatter, top level. Uses ftda_pkg and ftda_bcd.
// Input: raw single-precision bits. Output: one ASCII character per beat.
//
// Each accepted value is decoded on acceptance into a 32-bit integer part and
// a 59-bit exact binary fraction. The integer part then runs through a
// shift-and-add-3 converter at two bits per cycle, after which characters
// leave one per cycle unless the output stalls: optional '-', integer
// digits without leading zeros, then '.' and frac_digits truncated fraction
// digits, each fraction digit made by one multiply-by-ten step on the
// fraction register. A value prints up to 21 characters.
// The next value is taken once the last character is in the output register.
// NaN, infinity and magnitudes of 2^31 and above print 2147483647 with the
// overflow flag set on every character. frac_digits must be written over the
// cfg channel only while idle, which the block does not enforce; values above 9 act as 9.
module float_to_decimal_ascii_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_data_i,
  // value in
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] value_bits_i,
  // characters out
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  char_code_o,
  output logic        last_char_o,
  output logic        overflow_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CONV  = 3'd1;
  localparam logic [2:0] S_SIGN  = 3'd2;
  localparam logic [2:0] S_INT   = 3'd3;
  localparam logic [2:0] S_POINT = 3'd4;
  localparam logic [2:0] S_FRAC  = 3'd5;

  localparam int unsigned FW = ftda_pkg::FRAC_W;
  localparam int unsigned PW = FW + 4;    // width of fraction times ten

  logic [2:0] state_q, state_d;

  logic [ftda_pkg::FD_W-1:0] fd_q;
  logic [FW-1:0]             frac_q, frac_d;
  logic                      neg_q, ovf_q;
  logic [3:0]                nd_q;
  logic [3:0]                fcnt_q, fcnt_d;
  logic [3:0]                idx_q, idx_d;

  logic       out_valid_q, out_valid_d;
  logic [7:0] char_q, char_d;
  logic       last_q, last_d;
  logic       ovfo_q;

  // decode
  logic [7:0]                  expo;
  logic [22:0]                 mant;
  logic                        dec_ovf, dec_neg;
  logic [6:0]                  shamt;
  logic [ftda_pkg::FIX_W-1:0]  fix;
  logic [ftda_pkg::BIN_W-1:0]  dec_int;
  logic [FW-1:0]               dec_frac;
  logic [3:0]                  dec_nd;
  logic                        in_accept;

  // converter
  logic [ftda_pkg::BCD_W-1:0]  bcd;
  ftda_pkg::bcd_stat_t         bcd_stat;
  logic [3:0]                  bcd_dig [ftda_pkg::BCD_DIGITS];
  logic [3:0]                  top_idx;

  logic          adv, load;
  logic [PW-1:0] prod;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    expo    = value_bits_i[30:23];
    mant    = value_bits_i[22:0];
    dec_ovf = (expo == 8'hFF) || (expo >= 8'd158);
    dec_neg = value_bits_i[31] && !((expo == 8'hFF) && (mant != '0))
              && !((expo == 8'h00) && (mant == '0));
    // value = 1.mant * 2^(expo-150); fixed point with 59 fraction bits
    shamt = 7'(expo - 8'd91);
    fix   = '0;
    if (!dec_ovf && (expo >= 8'd91)) begin
      fix = {{(ftda_pkg::FIX_W-24){1'b0}}, 1'b1, mant} << shamt;
    end
    dec_int  = dec_ovf ? ftda_pkg::SAT_INT : fix[ftda_pkg::FIX_W-1:FW];
    dec_frac = dec_ovf ? '0 : fix[FW-1:0];
    dec_nd   = (fd_q > ftda_pkg::FD_MAX) ? ftda_pkg::FD_MAX : fd_q;
  end

  ftda_bcd u_bcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_accept),
    .bin_i   (dec_int),
    .bcd_o   (bcd),
    .stat_o  (bcd_stat)
  );

  // most significant nonzero digit, zero if all digits are zero
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < int'(ftda_pkg::BCD_DIGITS); i++) begin
      bcd_dig[i] = bcd[4*i +: 4];
      if (bcd[4*i +: 4] != 4'd0) begin
        top_idx = 4'(i);
      end
    end
  end

  assign prod = {1'b0, frac_q, 3'b000} + {3'b000, frac_q, 1'b0};
  assign adv  = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    fcnt_d  = fcnt_q;
    frac_d  = frac_q;
    load    = 1'b0;
    char_d  = char_q;
    last_d  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          frac_d  = dec_frac;
          state_d = S_CONV;
        end
      end
      S_CONV: begin
        if (bcd_stat.done) begin
          idx_d   = top_idx;
          state_d = neg_q ? S_SIGN : S_INT;
        end
      end
      S_SIGN: begin
        if (adv) begin
          load    = 1'b1;
          char_d  = ftda_pkg::CH_MINUS;
          state_d = S_INT;
        end
      end
      S_INT: begin
        if (adv) begin
          load   = 1'b1;
          char_d = ftda_pkg::CH_ZERO + {4'd0, bcd_dig[idx_q]};
          if (idx_q == 4'd0) begin
            if (nd_q == 4'd0) begin
              last_d  = 1'b1;
              state_d = S_IDLE;
            end else begin
              state_d = S_POINT;
            end
          end else begin
            idx_d = idx_q - 1'b1;
          end
        end
      end
      S_POINT: begin
        if (adv) begin
          load    = 1'b1;
          char_d  = ftda_pkg::CH_POINT;
          fcnt_d  = nd_q;
          state_d = S_FRAC;
        end
      end
      S_FRAC: begin
        if (adv) begin
          load   = 1'b1;
          char_d = ftda_pkg::CH_ZERO + {4'd0, prod[PW-1:FW]};
          frac_d = prod[FW-1:0];
          fcnt_d = fcnt_q - 1'b1;
          if (fcnt_q == 4'd1) begin
            last_d  = 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fd_q        <= ftda_pkg::FD_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        fd_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    frac_q <= frac_d;
    idx_q  <= idx_d;
    fcnt_q <= fcnt_d;
    if (in_accept) begin
      neg_q <= dec_neg;
      ovf_q <= dec_ovf;
      nd_q  <= dec_nd;
    end
    if (load) begin
      char_q <= char_d;
      last_q <= last_d;
      ovfo_q <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign char_code_o = char_q;
  assign last_char_o = last_q;
  assign overflow_o  = ovfo_q;

  // converter runs only while the value waits for its integer digits
  a_bcd_in_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bcd_stat.busy || bcd_stat.done) |-> (state_q == S_CONV))
    else $error("BCD converter active outside conversion");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INT) |-> (idx_q < 4'(ftda_pkg::BCD_DIGITS)))
    else $error("integer digit index out of range");

  a_frac_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FRAC) |-> ((fcnt_q != 4'd0) && (fcnt_q <= nd_q)))
    else $error("fraction digit count out of range");

  a_point_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (char_q == ftda_pkg::CH_POINT)) |-> !last_q)
    else $error("point flagged as last character");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && last_d) |=> (state_q == S_IDLE))
    else $error("last character did not end the value");

endmodule
